// ===== sv/shs_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
`default_nettype none
package shs_pkg;

  localparam int unsigned FILL_W  = 6;   // byte position inside a 64-byte block
  localparam int unsigned TOTAL_W = 61;  // message length in bytes, wraps
  localparam int unsigned ROUND_W = 6;   // 64 rounds per block

  // Initial hash value.
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    PAD_MARK = 2'd0,
    PAD_ZERO = 2'd1,
    PAD_LEN  = 2'd2
  } pad_kind_t;

  // Controller -> datapath.
  typedef struct packed {
    logic                 wr_byte;   // store the input byte at the fill position
    logic                 wr_pad;    // store a padding byte at the fill position
    pad_kind_t            pad_kind;
    logic                 ld_work;   // working vars <- hash words
    logic                 do_round;  // one compression round
    logic [ROUND_W-1:0]   rnd;
    logic                 fold;      // hash words += working vars
    logic                 reinit;    // back to the initial hash, empty message
    logic [1:0]           part;      // digest quarter on the output
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/shs_datapath.sv =====
// Datapath: block/schedule window, round logic, hash words, counters.
`default_nettype none
module shs_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire shs_pkg::cmd_t       cmd,
  input  wire logic [7:0]          in_data_byte,
  output shs_pkg::sts_t            sts,
  output logic [63:0]              digest_part
);

  logic [31:0] hash_r [8];
  logic [31:0] work_r [8];
  logic [31:0] w_r    [16];
  logic [shs_pkg::FILL_W-1:0]  fill_r;
  logic [shs_pkg::TOTAL_W-1:0] total_r;

  logic        wr_en;
  logic [7:0]  pad_byte;
  logic [7:0]  wr_val;
  logic [63:0] len_bits;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] ch;
  logic [31:0] maj;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign wr_en    = cmd.wr_byte | cmd.wr_pad;
  assign len_bits = {total_r, 3'b000};

  always_comb begin
    unique case (cmd.pad_kind)
      shs_pkg::PAD_MARK: pad_byte = 8'h80;
      shs_pkg::PAD_ZERO: pad_byte = 8'h00;
      shs_pkg::PAD_LEN:  pad_byte = len_bits[{~fill_r[2:0], 3'b000} +: 8];
      default:           pad_byte = 8'h00;
    endcase
  end

  assign wr_val = cmd.wr_byte ? in_data_byte : pad_byte;

  // Message schedule: window holds W[t..t+15], round t uses w_r[0].
  assign w_new = (ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9] +
                 (ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];

  assign s1  = ror(work_r[4], 6) ^ ror(work_r[4], 11) ^ ror(work_r[4], 25);
  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign t1  = work_r[7] + s1 + ch + shs_pkg::ROUND_K[cmd.rnd] + w_r[0];
  assign s0  = ror(work_r[0], 2) ^ ror(work_r[0], 13) ^ ror(work_r[0], 22);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t2  = s0 + maj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= shs_pkg::HASH_IV[i];
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + work_r[i];
      end else if (cmd.reinit) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= shs_pkg::HASH_IV[i];
      end
      if (cmd.reinit) begin
        fill_r  <= '0;
        total_r <= '0;
      end else begin
        if (wr_en)       fill_r  <= fill_r + 1'b1;
        if (cmd.wr_byte) total_r <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_work) begin
      for (int i = 0; i < 8; i++) work_r[i] <= hash_r[i];
    end else if (cmd.do_round) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= wr_val;
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  assign sts.fill    = fill_r;
  assign digest_part = {hash_r[{cmd.part, 1'b0}], hash_r[{cmd.part, 1'b1}]};

endmodule
`default_nettype wire

// ===== sv/shs_ctrl.sv =====
// Controller: sequences byte intake, padding, compression and digest output.
`default_nettype none
module shs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_byte_present,
  input  wire logic          in_end_of_message,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_part_index,
  output logic               out_last_part,
  input  wire shs_pkg::sts_t sts,
  output shs_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_COMP_INIT,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [shs_pkg::ROUND_W-1:0] rnd_r, rnd_nxt;
  logic [1:0] part_r, part_nxt;
  logic pend_r, pend_nxt;       // message end in progress
  logic marked_r, marked_nxt;   // 0x80 already stored
  logic fin_r, fin_nxt;         // current compression is the last one
  logic in_txn;
  logic fill_full;

  assign in_txn    = in_valid && in_ready;
  assign fill_full = (sts.fill == '1);

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    part_nxt   = part_r;
    pend_nxt   = pend_r;
    marked_nxt = marked_r;
    fin_nxt    = fin_r;
    cmd        = '0;
    cmd.rnd    = rnd_r;
    cmd.part   = part_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_txn) begin
          cmd.wr_byte = in_byte_present;
          if (in_byte_present && fill_full) begin
            pend_nxt  = in_end_of_message;
            state_nxt = S_COMP_INIT;
          end else if (in_end_of_message) begin
            pend_nxt  = 1'b1;
            state_nxt = S_PAD_MARK;
          end
        end
      end
      S_PAD_MARK: begin
        cmd.wr_pad   = 1'b1;
        cmd.pad_kind = shs_pkg::PAD_MARK;
        marked_nxt   = 1'b1;
        state_nxt    = fill_full ? S_COMP_INIT : S_PAD_ZERO;
      end
      S_PAD_ZERO: begin
        if (sts.fill == shs_pkg::FILL_W'(56)) begin
          state_nxt = S_PAD_LEN;
        end else begin
          cmd.wr_pad   = 1'b1;
          cmd.pad_kind = shs_pkg::PAD_ZERO;
          if (fill_full) state_nxt = S_COMP_INIT;
        end
      end
      S_PAD_LEN: begin
        cmd.wr_pad   = 1'b1;
        cmd.pad_kind = shs_pkg::PAD_LEN;
        if (fill_full) begin
          fin_nxt   = 1'b1;
          state_nxt = S_COMP_INIT;
        end
      end
      S_COMP_INIT: begin
        cmd.ld_work = 1'b1;
        rnd_nxt     = '0;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == '1) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        priority if (fin_r) begin
          part_nxt  = '0;
          state_nxt = S_OUT;
        end else if (!pend_r) begin
          state_nxt = S_IDLE;
        end else if (!marked_r) begin
          state_nxt = S_PAD_MARK;
        end else begin
          state_nxt = S_PAD_ZERO;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          part_nxt = part_r + 1'b1;
          if (part_r == 2'd3) begin
            cmd.reinit = 1'b1;
            pend_nxt   = 1'b0;
            marked_nxt = 1'b0;
            fin_nxt    = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rnd_r    <= '0;
      part_r   <= '0;
      pend_r   <= 1'b0;
      marked_r <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      part_r   <= part_nxt;
      pend_r   <= pend_nxt;
      marked_r <= marked_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_part_index = part_r;
  assign out_last_part  = (part_r == 2'd3);

endmodule
`default_nettype wire

// ===== sv/sha256_stream_hasher_unit.sv =====
// Intake: in_ready drops while a compression runs; every 64th byte starts a compression
//   (load, 64 rounds at one round per cycle, fold into the hash words).
// End of message: padding plus one or two compressions, then four
//   digest transactions, one per cycle while out_ready is high.
// Reset: synchronous active-low rst_n restores the initial hash and clears all counters.
`default_nettype none
module sha256_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_part,
  output logic [1:0]       out_part_index,
  output logic             out_last_part
);

  // Command and status between the sequencer and the datapath.
  shs_pkg::cmd_t cmd;
  shs_pkg::sts_t sts;

  // Sequencer: takes one input transaction at a time. A byte lands in the
  // 16-word window at the fill position; a full window triggers compression.
  // An end-of-message transaction walks through padding (0x80, zeros, the
  // 64-bit bit length), which may need an extra block, then presents the
  // digest as four transactions before returning to the idle state.
  shs_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_part_index    (out_part_index),
    .out_last_part     (out_last_part),
    .sts               (sts),
    .cmd               (cmd)
  );

  // Datapath: the window doubles as block buffer and message schedule, so
  // the block bytes and the expanded words share one set of registers. The
  // digest is read straight from the hash word registers, which hold still
  // while the output waits.
  shs_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .sts          (sts),
    .digest_part  (out_digest_part)
  );

endmodule
`default_nettype wire

// ===== sv/shs_checker.sv =====
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
`default_nettype none
module shs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_digest_part,
  input wire logic [1:0]  out_part_index,
  input wire logic        out_last_part
);

  // One transaction in flight: no intake while a digest is presented.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest is presented");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_part == (out_part_index == 2'd3)))
    else $error("last_part does not match part index");

  a_part_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_part) |=>
      (out_valid && out_part_index == 2'($past(out_part_index) + 2'd1)))
    else $error("digest parts not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_part) && $stable(out_part_index)))
    else $error("stalled digest transaction changed");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_part (out_digest_part),
  .out_part_index  (out_part_index),
  .out_last_part   (out_last_part)
);
`default_nettype wire
